### hw/rtl/tsoq_pkg.sv
// ----------------------------------------------------------------------------
// tsoq_pkg: shared types and constants
// Record layout, operation codes and compare results for the time sorted
// order queue.
// ----------------------------------------------------------------------------
package tsoq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam logic [7:0] PERISH_TYPE = 8'h50;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_MARK = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef struct packed {
    logic [15:0] arr_time;
    logic [7:0]  pickup;
    logic [7:0]  dropoff;
    logic [7:0]  itype;
    logic        perish_valid;
    logic [15:0] perish;
    logic        done;
  } entry_t;

  typedef struct packed {
    logic [15:0] arr_time;
    logic [7:0]  pickup;
    logic [7:0]  dropoff;
    logic [7:0]  itype;
  } key_t;

  typedef struct packed {
    logic time_lt;
    logic match;
  } cmp_t;

endpackage

### hw/rtl/time_sorted_order_queue.sv
// ----------------------------------------------------------------------------
// time_sorted_order_queue: bounded queue of order records sorted by time
// Records live in a RAM; a small sequencer walks it one entry at a time.
// ----------------------------------------------------------------------------
// usage:
//   s_axis: one command item; tuser holds the operation (enqueue, dequeue
//   earliest, mark matching done), tdata the record fields.
//   m_axis: one result item per command, with ok, the popped record
//   (zeros unless a dequeue succeeded), count, empty and full.
// timing:
//   one command at a time; s_axis_tready is high only while idle.
//   each entry visit is a RAM read, then a compare and write back, set
//   by the single registered read port of the record RAM.
//   enqueue and dequeue visit all live entries; mark-done stops at the match.
//   a refused enqueue or unused code goes straight to the result.
// reset:
//   rst empties the queue at once; RAM contents are not cleared.
// stall:
//   a result waits in the output register; the next command is accepted
//   meanwhile and finishes once the register is free.
// ----------------------------------------------------------------------------
module time_sorted_order_queue import tsoq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // time[15:0], pickup[23:16], dropoff[31:24], item_type[39:32], perish_time[55:40]
  input  logic [55:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // ok, out_time, out_pickup, out_dropoff, out_type, out_perish, out_done,
  // count, is_empty, is_full, zero pad
  output logic [((61 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RAW_W = 61 + CW;
  localparam int OUT_W = ((RAW_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RD     = 4'b0010,
    ST_PROC   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t      state;
  func_t       op;
  key_t        key;
  logic [15:0] key_perish;
  logic [CW-1:0] idx;
  logic [CW-1:0] cnt;
  entry_t      carry;
  logic        ins;
  entry_t      pop_rec;
  logic        res_ok;
  logic        res_pop;

  entry_t      new_rec;
  entry_t      rdata;
  entry_t      wdata;
  logic        we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] idx_dec;
  logic        at_end;
  cmp_t        cmp;
  logic        out_free;
  logic [16:0] res_perish;
  logic [OUT_W-1:0] out_word;

  assign s_axis_tready = (state == ST_IDLE);
  assign at_end   = (idx == cnt);
  assign idx_dec  = idx - CW'(1);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    new_rec.arr_time     = key.arr_time;
    new_rec.pickup       = key.pickup;
    new_rec.dropoff      = key.dropoff;
    new_rec.itype        = key.itype;
    new_rec.perish_valid = (key.itype == PERISH_TYPE);
    new_rec.perish       = new_rec.perish_valid ? key_perish : 16'd0;
    new_rec.done         = 1'b0;
  end

  tsoq_cmp u_cmp (
    .entry (rdata),
    .key   (key),
    .res   (cmp)
  );

  tsoq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = new_rec;
    if (state == ST_RD && op == FN_ENQ && at_end) begin
      we    = 1'b1;
      wdata = ins ? carry : new_rec;
    end else if (state == ST_PROC) begin
      unique case (op)
        FN_ENQ: begin
          if (ins) begin
            we    = 1'b1;
            wdata = carry;
          end else if (!cmp.time_lt) begin
            we    = 1'b1;
            wdata = new_rec;
          end
        end
        FN_DEQ: begin
          if (idx != '0) begin
            we    = 1'b1;
            waddr = idx_dec[AW-1:0];
            wdata = rdata;
          end
        end
        FN_MARK: begin
          if (cmp.match) begin
            we         = 1'b1;
            wdata      = rdata;
            wdata.done = 1'b1;
          end
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_comb begin
    res_perish = pop_rec.perish_valid ? {1'b0, pop_rec.perish} : 17'h1FFFF;
    out_word   = '0;
    out_word[0] = res_ok;
    if (res_pop) begin
      out_word[16:1]  = pop_rec.arr_time;
      out_word[24:17] = pop_rec.pickup;
      out_word[32:25] = pop_rec.dropoff;
      out_word[40:33] = pop_rec.itype;
      out_word[57:41] = res_perish;
      out_word[58]    = pop_rec.done;
    end
    out_word[59 +: CW]   = cnt;
    out_word[59 + CW]    = (cnt == '0);
    out_word[60 + CW]    = (cnt == CW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_FINISH) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op             <= func_t'(s_axis_tuser);
            key.arr_time   <= s_axis_tdata[15:0];
            key.pickup     <= s_axis_tdata[23:16];
            key.dropoff    <= s_axis_tdata[31:24];
            key.itype      <= s_axis_tdata[39:32];
            key_perish     <= s_axis_tdata[55:40];
            idx            <= '0;
            ins            <= 1'b0;
            res_ok         <= 1'b0;
            res_pop        <= 1'b0;
            if (func_t'(s_axis_tuser) == FN_NONE ||
                (func_t'(s_axis_tuser) == FN_ENQ && cnt == CW'(DEPTH))) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          if (at_end) begin
            state <= ST_FINISH;
            case (op)
              FN_ENQ: begin
                cnt    <= cnt + CW'(1);
                res_ok <= 1'b1;
              end
              FN_DEQ: begin
                if (cnt != '0) begin
                  cnt     <= cnt - CW'(1);
                  res_ok  <= 1'b1;
                  res_pop <= 1'b1;
                end
              end
              default: res_ok <= 1'b0;
            endcase
          end else begin
            state <= ST_PROC;
          end
        end
        ST_PROC: begin
          state <= ST_RD;
          idx   <= idx + CW'(1);
          case (op)
            FN_ENQ: begin
              if (ins || !cmp.time_lt) begin
                ins   <= 1'b1;
                carry <= rdata;
              end
            end
            FN_DEQ: begin
              if (idx == '0) begin
                pop_rec <= rdata;
              end
            end
            FN_MARK: begin
              if (cmp.match) begin
                res_ok <= 1'b1;
                state  <= ST_FINISH;
              end
            end
            default: ins <= ins;
          endcase
        end
        ST_FINISH: begin
          if (out_free) begin
            m_axis_tdata  <= out_word;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_write_live: assert property (@(posedge clk) disable iff (rst)
    we |-> (idx <= cnt) && (state == ST_RD || state == ST_PROC))
    else $error("ram write outside the live range");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[59 + CW] == (m_axis_tdata[59 +: CW] == '0)))
    else $error("empty flag disagrees with count");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD && at_end && op == FN_DEQ && cnt != '0) |=> (cnt == $past(cnt) - CW'(1)))
    else $error("dequeue did not shrink the queue");

endmodule

### hw/rtl/tsoq_ram.sv
// ----------------------------------------------------------------------------
// tsoq_ram: generic memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsoq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tsoq_cmp.sv
// ----------------------------------------------------------------------------
// tsoq_cmp: shared record compare unit
// Compares one stored record against the search key: time order and full
// match on time, pickup, dropoff and item type.
// ----------------------------------------------------------------------------
module tsoq_cmp import tsoq_pkg::*; (
  input  entry_t entry,
  input  key_t   key,
  output cmp_t   res
);

  always_comb begin
    res.time_lt = entry.arr_time < key.arr_time;
    res.match   = (entry.arr_time == key.arr_time) && (entry.pickup == key.pickup) &&
                  (entry.dropoff == key.dropoff) && (entry.itype == key.itype);
  end

endmodule

### test/tsoq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsoq_checker: result checker for the time sorted order queue
// Watches both stream channels. Every accepted command item is run through
// a behavioral copy of the sorted queue and the expected result item is
// queued. Every result item is compared field by field against the oldest
// expected result. Mismatches and the number of outstanding results are
// handed back to the testbench top.
// ----------------------------------------------------------------------------
module tsoq_checker import tsoq_pkg::*; #(
  parameter int RES_W = 72
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,
  input  logic [1:0]       s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [RES_W-1:0] m_axis_tdata,
  output int               mismatches,
  output int               pending
);

  localparam int CNT_W = $clog2(DEPTH_DEF + 1);

  typedef struct packed {
    logic [15:0] perish;
    logic [7:0]  itype;
    logic [7:0]  dropoff;
    logic [7:0]  pickup;
    logic [15:0] arr_time;
  } order_cmd_t;

  typedef struct packed {
    logic [RES_W-62-CNT_W:0] pad;
    logic                    is_full;
    logic                    is_empty;
    logic [CNT_W-1:0]        count;
    logic                    done;
    logic [16:0]             perish;
    logic [7:0]              itype;
    logic [7:0]              dropoff;
    logic [7:0]              pickup;
    logic [15:0]             arr_time;
    logic                    ok;
  } order_result_t;

  entry_t        order_store [DEPTH_DEF];
  int            live_orders;
  order_result_t expected_results [$];
  order_result_t want;
  order_result_t got;

  // updates the queue copy and returns the result item for one command
  function automatic order_result_t apply_order(func_t fn, order_cmd_t c);
    order_result_t r;
    entry_t        e;
    int            pos;
    int            k;
    r = '0;
    case (fn)
      FN_ENQ: begin
        if (live_orders < DEPTH_DEF) begin
          pos = 0;
          while (pos < live_orders && order_store[pos].arr_time < c.arr_time) pos++;
          for (k = live_orders; k > pos; k--) order_store[k] = order_store[k - 1];
          e.arr_time     = c.arr_time;
          e.pickup       = c.pickup;
          e.dropoff      = c.dropoff;
          e.itype        = c.itype;
          e.perish_valid = (c.itype == PERISH_TYPE);
          e.perish       = e.perish_valid ? c.perish : 16'h0000;
          e.done         = 1'b0;
          order_store[pos] = e;
          live_orders++;
          r.ok = 1'b1;
        end
      end
      FN_DEQ: begin
        if (live_orders > 0) begin
          e = order_store[0];
          for (k = 1; k < live_orders; k++) order_store[k - 1] = order_store[k];
          live_orders--;
          r.ok       = 1'b1;
          r.arr_time = e.arr_time;
          r.pickup   = e.pickup;
          r.dropoff  = e.dropoff;
          r.itype    = e.itype;
          r.perish   = e.perish_valid ? {1'b0, e.perish} : 17'h1FFFF;
          r.done     = e.done;
        end
      end
      FN_MARK: begin
        for (k = 0; k < live_orders; k++) begin
          if (order_store[k].arr_time == c.arr_time && order_store[k].pickup == c.pickup &&
              order_store[k].dropoff == c.dropoff && order_store[k].itype == c.itype) begin
            order_store[k].done = 1'b1;
            r.ok = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.count    = CNT_W'(live_orders);
    r.is_empty = (live_orders == 0);
    r.is_full  = (live_orders >= DEPTH_DEF);
    return r;
  endfunction

  task automatic check_field(string name, logic [16:0] exp_val, logic [16:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      live_orders = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result expected none actual %0h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", 17'(want.ok), 17'(got.ok));
          check_field("out_time", 17'(want.arr_time), 17'(got.arr_time));
          check_field("out_pickup", 17'(want.pickup), 17'(got.pickup));
          check_field("out_dropoff", 17'(want.dropoff), 17'(got.dropoff));
          check_field("out_type", 17'(want.itype), 17'(got.itype));
          check_field("out_perish", want.perish, got.perish);
          check_field("out_done", 17'(want.done), 17'(got.done));
          check_field("count", 17'(want.count), 17'(got.count));
          check_field("is_empty", 17'(want.is_empty), 17'(got.is_empty));
          check_field("is_full", 17'(want.is_full), 17'(got.is_full));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_order(func_t'(s_axis_tuser), order_cmd_t'(s_axis_tdata)));
      end
    end
    pending = expected_results.size();
  end

endmodule

### test/tb_time_sorted_order_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_sorted_order_queue: testbench for the time sorted order queue
// Drives command items with random gaps, result backpressure with random
// stalls and one long hold-off, a directed opening and about 1200 random
// commands in fill, drain and balanced phases. Checking is done by
// tsoq_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_time_sorted_order_queue;
  import tsoq_pkg::*;

  localparam int RES_W       = ((61 + $clog2(DEPTH_DEF + 1) + 7) / 8) * 8;
  localparam int NUM_RANDOM  = 1200;
  localparam int QUIET_FROM  = 1000;
  localparam int CYCLE_LIMIT = 600000;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [55:0]      s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [RES_W-1:0] m_axis_tdata;
  int               mismatches;
  int               pending;
  int               cycles;
  bit               tx_idle_on;
  bit               rx_stall_on;
  bit               long_hold_req;
  bit               long_hold_done;
  logic [39:0]      recent_keys [$];

  time_sorted_order_queue #(.DEPTH(DEPTH_DEF)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  tsoq_checker #(.RES_W(RES_W)) order_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready  = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_order(func_t fn, logic [15:0] t, logic [7:0] pu, logic [7:0] dr,
                            logic [7:0] ty, logic [15:0] pt);
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {pt, ty, dr, pu, t};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (fn == FN_ENQ) begin
      recent_keys.push_back({ty, dr, pu, t});
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_order(int enq_pct);
    int          roll;
    func_t       fn;
    logic [15:0] t;
    logic [7:0]  pu;
    logic [7:0]  dr;
    logic [7:0]  ty;
    logic [15:0] pt;
    roll = $urandom_range(0, 99);
    if (roll < 2) fn = FN_NONE;
    else if (roll < 17) fn = FN_MARK;
    else if (roll < 17 + (83 * enq_pct) / 100) fn = FN_ENQ;
    else fn = FN_DEQ;
    case ($urandom_range(0, 3))
      0: t = 16'($urandom_range(0, 15));
      3: t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: t = 16'($urandom);
    endcase
    pu = 8'($urandom);
    dr = 8'($urandom);
    ty = $urandom_range(0, 1) ? PERISH_TYPE : 8'($urandom);
    pt = 16'($urandom);
    if (fn == FN_MARK && recent_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
      {ty, dr, pu, t} = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end
    send_order(fn, t, pu, dr, ty, pt);
  endtask

  initial begin
    int i;
    int enq_pct;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FN_NONE;
    tx_idle_on    = 1'b1;
    rx_stall_on   = 1'b1;
    long_hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, unused code, field extremes, equal times, done marking
    send_order(FN_DEQ, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_order(FN_MARK, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_order(FN_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_order(FN_ENQ, 16'hFFFF, 8'hFF, 8'hFF, PERISH_TYPE, 16'hFFFF);
    send_order(FN_ENQ, 16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF);
    send_order(FN_ENQ, 16'h1234, 8'h41, 8'h42, PERISH_TYPE, 16'h0000);
    send_order(FN_ENQ, 16'h1234, 8'hAA, 8'h55, 8'h51, 16'h5555);
    send_order(FN_ENQ, 16'h1234, 8'h41, 8'h42, PERISH_TYPE, 16'h7777);
    send_order(FN_MARK, 16'h1234, 8'h41, 8'h42, PERISH_TYPE, 16'h0000);
    send_order(FN_MARK, 16'h1234, 8'h41, 8'h42, PERISH_TYPE, 16'h0000);
    send_order(FN_MARK, 16'h1234, 8'h41, 8'h42, 8'h52, 16'h0000);
    send_order(FN_MARK, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_order(FN_ENQ, 16'h8000, 8'h5A, 8'hA5, 8'hAF, 16'hAAAA);
    send_order(FN_NONE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    repeat (7) send_order(FN_DEQ, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    wait_drained();

    for (i = 0; i < NUM_RANDOM; i++) begin
      case ((i / 80) % 3)
        0: enq_pct = 75;
        1: enq_pct = 25;
        default: enq_pct = 50;
      endcase
      tx_idle_on  = (i < QUIET_FROM) && ((i / 150) % 3 != 2);
      rx_stall_on = (i < QUIET_FROM) && ((i / 120) % 3 != 1);
      if (i == 400) long_hold_req = 1'b1;
      if (i == 700) wait_drained();
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      random_order(enq_pct);
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### time_sorted_order_queue.f
hw/rtl/tsoq_pkg.sv
hw/rtl/tsoq_ram.sv
hw/rtl/tsoq_cmp.sv
hw/rtl/time_sorted_order_queue.sv
test/tsoq_checker.sv
test/tb_time_sorted_order_queue.sv
